// File: rtl/core/hsk_pkg.sv
// Package for the keyed-record heapsort block: record layout, command and
// status structures shared by the controller, the datapath and the top level.
// Depends on nothing.
package hsk_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned PartW       = 16;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [PartW-1:0] first;
    logic [PartW-1:0] second;
  } rec_t;

  // Commands from the controller to the datapath; several may be set together.
  typedef struct packed {
    logic store;
    logic build_init;
    logic ld_build;
    logic hold_build;
    logic build_dec;
    logic sort_init;
    logic ld_sort;
    logic swap;
    logic sort_dec;
    logic sift_rd;
    logic sift_cmp;
    logic out_ld;
    logic out_next;
    logic clear_set;
  } cmd_t;

  typedef struct packed {
    logic lt2;
    logic pos_zero;
    logic pos_one;
    logic child_gt_end;
    logic sift_stop;
    logic out_last;
  } sts_t;

endpackage

// File: rtl/core/heapsort_keyed_records.sv
// Keyed-record heapsort. Records are taken one per cycle while collecting.
// After the last record, the in-place heapsort builds the heap and sorts it
// down; each sift level reads both children from the two-port record memory,
// then compares. Results follow one per cycle while out_stall_i is low, after
// a registered memory load. Reset empties the set; the memory is not cleared.
module heapsort_keyed_records #(
  parameter int unsigned CAPACITY = hsk_pkg::DefCapacity
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [hsk_pkg::KeyW-1:0]  time_key_i,
  input  logic [hsk_pkg::PartW-1:0] first_particle_i,
  input  logic [hsk_pkg::PartW-1:0] second_particle_i,
  input  logic                      last_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [hsk_pkg::KeyW-1:0]  sorted_key_o,
  output logic [hsk_pkg::PartW-1:0] sorted_first_o,
  output logic [hsk_pkg::PartW-1:0] sorted_second_o,
  output logic                      last_result_o,
  output logic                      dropped_flag_o
);
  import hsk_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rec_t in_rec, out_rec;

  assign in_rec.key    = time_key_i;
  assign in_rec.first  = first_particle_i;
  assign in_rec.second = second_particle_i;

  hsk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  hsk_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_rec_i       (in_rec),
    .sts_o          (sts),
    .out_rec_o      (out_rec),
    .last_result_o  (last_result_o),
    .dropped_flag_o (dropped_flag_o)
  );

  assign sorted_key_o    = out_rec.key;
  assign sorted_first_o  = out_rec.first;
  assign sorted_second_o = out_rec.second;

`ifndef SYNTHESIS
  // Input is never taken while a sorted run is being delivered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input accepted while output is valid");

  // The final transaction of a run ends the output.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_result_o |=> !out_valid_o)
    else $error("output continues after the final record");

  // The overflow flag is the same on every record of a run.
  a_drop_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o) |-> $stable(dropped_flag_o))
    else $error("dropped flag changed within a run");

  // Sorting only starts once a set has been closed.
  a_store_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |-> !cmd.sift_rd && !cmd.sift_cmp && !out_valid_o)
    else $error("record stored while sorting or emitting");
`endif

endmodule

// File: rtl/core/hsk_ctrl.sv
// Controller of the keyed-record heapsort: a one-hot state machine that
// sequences collection, heap build, sort-down and output.
// Depends on hsk_pkg.
module hsk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_item_i,
  input  logic          out_stall_i,
  input  hsk_pkg::sts_t sts_i,
  output hsk_pkg::cmd_t cmd_o,
  output logic          in_stall_o,
  output logic          out_valid_o
);
  import hsk_pkg::*;

  typedef enum logic [9:0] {
    S_COLLECT  = 10'b0000000001,
    S_START    = 10'b0000000010,
    S_BLD_LD   = 10'b0000000100,
    S_BLD_HOLD = 10'b0000001000,
    S_SRT_LD   = 10'b0000010000,
    S_SRT_SWAP = 10'b0000100000,
    S_SIFT_RD  = 10'b0001000000,
    S_SIFT_CMP = 10'b0010000000,
    S_OUT_LD   = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   sorting_q, sorting_d;
  logic   sift_done;
  state_e after_sift;

  assign in_stall_o  = (state_q != S_COLLECT);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    sorting_d  = sorting_q;
    sift_done  = 1'b0;
    after_sift = S_SRT_LD;

    case (state_q)
      S_COLLECT: begin
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (last_item_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (sts_i.lt2) begin
          state_d = S_OUT_LD;
        end else begin
          cmd_o.build_init = 1'b1;
          state_d          = S_BLD_LD;
        end
      end
      S_BLD_LD: begin
        cmd_o.ld_build = 1'b1;
        state_d        = S_BLD_HOLD;
      end
      S_BLD_HOLD: begin
        cmd_o.hold_build = 1'b1;
        sorting_d        = 1'b0;
        state_d          = S_SIFT_RD;
      end
      S_SRT_LD: begin
        cmd_o.ld_sort = 1'b1;
        state_d       = S_SRT_SWAP;
      end
      S_SRT_SWAP: begin
        cmd_o.swap = 1'b1;
        sorting_d  = 1'b1;
        state_d    = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        cmd_o.sift_rd = 1'b1;
        if (sts_i.child_gt_end) begin
          sift_done = 1'b1;
        end else begin
          state_d = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        cmd_o.sift_cmp = 1'b1;
        if (sts_i.sift_stop) begin
          sift_done = 1'b1;
        end else begin
          state_d = S_SIFT_RD;
        end
      end
      S_OUT_LD: begin
        cmd_o.out_ld = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          cmd_o.out_next = 1'b1;
          if (sts_i.out_last) begin
            cmd_o.clear_set = 1'b1;
            state_d         = S_COLLECT;
          end
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase

    // Once a sift-down has placed its held record, pick the next heap step.
    if (sift_done) begin
      if (!sorting_q) begin
        if (sts_i.pos_zero) begin
          cmd_o.sort_init = 1'b1;
          after_sift      = S_SRT_LD;
        end else begin
          cmd_o.build_dec = 1'b1;
          after_sift      = S_BLD_LD;
        end
      end else begin
        if (sts_i.pos_one) begin
          after_sift = S_OUT_LD;
        end else begin
          cmd_o.sort_dec = 1'b1;
          after_sift     = S_SRT_LD;
        end
      end
      state_d = after_sift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COLLECT;
      sorting_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sorting_q <= sorting_d;
    end
  end

endmodule

// File: rtl/core/hsk_dpath.sv
// Datapath of the keyed-record heapsort: record memory with one write and
// two registered read ports, heap indices, held record and key comparators.
// Depends on hsk_pkg.
module hsk_dpath #(
  parameter int unsigned CAPACITY = hsk_pkg::DefCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hsk_pkg::cmd_t cmd_i,
  input  hsk_pkg::rec_t in_rec_i,
  output hsk_pkg::sts_t sts_o,
  output hsk_pkg::rec_t out_rec_o,
  output logic          last_result_o,
  output logic          dropped_flag_o
);
  import hsk_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ChW  = IdxW + 1;

  rec_t mem_q [CAPACITY];
  rec_t rd_a_q, rd_b_q;
  rec_t h_q, h_d;

  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] hole_q, hole_d;
  logic [IdxW-1:0] end_q, end_d;
  logic [IdxW-1:0] oidx_q, oidx_d;
  logic [ChW-1:0]  child_q, child_d;

  logic            wr_en, rd_a_en, rd_b_en;
  logic [IdxW-1:0] wr_addr, rd_a_addr, rd_b_addr;
  rec_t            wr_data;

  logic            full, child_gt_end, has_right, pick_b, ge_a, ge_b, stop;
  logic [IdxW-1:0] child_lo, child_hi, sel_idx;
  rec_t            sel_rec;

  assign full         = (count_q == CntW'(CAPACITY));
  assign child_gt_end = (child_q > {1'b0, end_q});
  assign has_right    = (child_q < {1'b0, end_q});
  assign child_lo     = child_q[IdxW-1:0];
  assign child_hi     = IdxW'(child_q + ChW'(1));

  // The left child wins a tie; sifting stops when the held key is not smaller.
  assign pick_b  = has_right && (rd_a_q.key < rd_b_q.key);
  assign ge_a    = (h_q.key >= rd_a_q.key);
  assign ge_b    = (h_q.key >= rd_b_q.key);
  assign stop    = pick_b ? ge_b : ge_a;
  assign sel_rec = pick_b ? rd_b_q : rd_a_q;
  assign sel_idx = pick_b ? child_hi : child_lo;

  always_comb begin
    count_d   = count_q;
    ovf_d     = ovf_q;
    pos_d     = pos_q;
    hole_d    = hole_q;
    end_d     = end_q;
    oidx_d    = oidx_q;
    child_d   = child_q;
    h_d       = h_q;
    wr_en     = 1'b0;
    wr_addr   = hole_q;
    wr_data   = h_q;
    rd_a_en   = 1'b0;
    rd_a_addr = child_lo;
    rd_b_en   = 1'b0;
    rd_b_addr = child_hi;

    if (cmd_i.store) begin
      if (!full) begin
        wr_en   = 1'b1;
        wr_addr = count_q[IdxW-1:0];
        wr_data = in_rec_i;
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.build_init) begin
      pos_d = IdxW'((count_q >> 1) - 1'b1);
    end
    if (cmd_i.ld_build) begin
      rd_a_en   = 1'b1;
      rd_a_addr = pos_q;
    end
    if (cmd_i.hold_build) begin
      h_d     = rd_a_q;
      hole_d  = pos_q;
      child_d = {pos_q, 1'b1};
      end_d   = IdxW'(count_q - 1'b1);
    end
    if (cmd_i.build_dec || cmd_i.sort_dec) begin
      pos_d = pos_q - 1'b1;
    end
    if (cmd_i.sort_init) begin
      pos_d = IdxW'(count_q - 1'b1);
    end
    if (cmd_i.ld_sort) begin
      rd_a_en   = 1'b1;
      rd_a_addr = '0;
      rd_b_en   = 1'b1;
      rd_b_addr = pos_q;
    end
    // The old root goes to the end; the end record becomes the held record.
    if (cmd_i.swap) begin
      wr_en   = 1'b1;
      wr_addr = pos_q;
      wr_data = rd_a_q;
      h_d     = rd_b_q;
      hole_d  = '0;
      child_d = ChW'(1);
      end_d   = pos_q - 1'b1;
    end
    if (cmd_i.sift_rd) begin
      if (child_gt_end) begin
        wr_en = 1'b1;
      end else begin
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
      end
    end
    if (cmd_i.sift_cmp) begin
      wr_en = 1'b1;
      if (!stop) begin
        wr_data = sel_rec;
        hole_d  = sel_idx;
        child_d = {sel_idx, 1'b1};
      end
    end
    if (cmd_i.out_ld) begin
      rd_a_en   = 1'b1;
      rd_a_addr = '0;
      oidx_d    = '0;
    end
    if (cmd_i.out_next) begin
      rd_a_en   = 1'b1;
      rd_a_addr = oidx_q + 1'b1;
      oidx_d    = oidx_q + 1'b1;
    end
    if (cmd_i.clear_set) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_q <= mem_q[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_q <= mem_q[rd_b_addr];
    end
    h_q <= h_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      hole_q  <= '0;
      end_q   <= '0;
      oidx_q  <= '0;
      child_q <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      hole_q  <= hole_d;
      end_q   <= end_d;
      oidx_q  <= oidx_d;
      child_q <= child_d;
    end
  end

  assign sts_o.lt2          = (count_q < CntW'(2));
  assign sts_o.pos_zero     = (pos_q == '0);
  assign sts_o.pos_one      = (pos_q == IdxW'(1));
  assign sts_o.child_gt_end = child_gt_end;
  assign sts_o.sift_stop    = stop;
  assign sts_o.out_last     = (oidx_q == IdxW'(count_q - 1'b1));

  assign out_rec_o      = rd_a_q;
  assign last_result_o  = sts_o.out_last;
  assign dropped_flag_o = ovf_q;

endmodule
